>>> hdl/lgste_pkg.sv
package lgste_pkg;

   // Table and word geometry
   localparam int TABLE_WORDS   = 97;
   localparam int BITS_PER_WORD = 24;
   localparam int WORD_W        = 24;
   localparam int INDEX_W       = 7;
   localparam int SEED_W        = 15;
   localparam int LAG_W         = 8;

   // Seed reduction and split
   localparam int SEED_A_MOD   = 31329;
   localparam int SEED_B_MOD   = 30082;
   localparam int SEED_A_DIV   = 177;
   localparam int SEED_A_RECIP = 370;   // floor(2^16 / 177)
   localparam int SEED_B_DIV   = 169;
   localparam int SEED_B_RECIP = 387;   // floor(2^16 / 169)

   // Lag product and congruential update
   localparam int LAG_MOD    = 179;
   localparam int LAG_RECIP  = 366;     // floor(2^16 / 179)
   localparam int CONG_MOD   = 169;
   localparam int CONG_RECIP = 387;
   localparam int CONG_MULT  = 53;
   localparam int BIT_POS    = 5;       // (x mod 64) >= 32

   // Micro-op codes
   typedef enum logic [3:0] {
      UOP_WAIT,
      UOP_SEED_QUOT,
      UOP_SEED_SET,
      UOP_MUL_IJ,
      UOP_RED_1,
      UOP_MUL_K,
      UOP_RED_2,
      UOP_SHIFT_BIT,
      UOP_EMIT_WORD,
      UOP_EMIT_EXH
   } uop_type;

   // Sequencing codes
   typedef enum logic [1:0] {
      JC_NEXT,
      JC_ALWAYS,
      JC_DISPATCH,
      JC_BITS_LEFT
   } jump_type;

   typedef logic [3:0] uc_addr_type;

   localparam uc_addr_type UC_IDLE      = 4'd0;
   localparam uc_addr_type UC_SEED_QUOT = 4'd1;
   localparam uc_addr_type UC_SEED_SET  = 4'd2;
   localparam uc_addr_type UC_MUL_IJ    = 4'd3;
   localparam uc_addr_type UC_RED_1     = 4'd4;
   localparam uc_addr_type UC_MUL_K     = 4'd5;
   localparam uc_addr_type UC_RED_2     = 4'd6;
   localparam uc_addr_type UC_SHIFT_BIT = 4'd7;
   localparam uc_addr_type UC_EMIT_WORD = 4'd8;
   localparam uc_addr_type UC_EMIT_EXH  = 4'd9;

   typedef struct packed {
      uop_type     uop;
      jump_type    jc;
      uc_addr_type target;
   } ucode_type;

   // Control store
   function automatic ucode_type ucode_rom(input uc_addr_type addr);
      ucode_type w;
      case (addr)
         UC_IDLE:      w = '{UOP_WAIT,      JC_DISPATCH,  UC_IDLE};
         UC_SEED_QUOT: w = '{UOP_SEED_QUOT, JC_NEXT,      UC_IDLE};
         UC_SEED_SET:  w = '{UOP_SEED_SET,  JC_ALWAYS,    UC_EMIT_EXH};
         UC_MUL_IJ:    w = '{UOP_MUL_IJ,    JC_NEXT,      UC_IDLE};
         UC_RED_1:     w = '{UOP_RED_1,     JC_NEXT,      UC_IDLE};
         UC_MUL_K:     w = '{UOP_MUL_K,     JC_NEXT,      UC_IDLE};
         UC_RED_2:     w = '{UOP_RED_2,     JC_NEXT,      UC_IDLE};
         UC_SHIFT_BIT: w = '{UOP_SHIFT_BIT, JC_BITS_LEFT, UC_MUL_IJ};
         UC_EMIT_WORD: w = '{UOP_EMIT_WORD, JC_ALWAYS,    UC_IDLE};
         UC_EMIT_EXH:  w = '{UOP_EMIT_EXH,  JC_ALWAYS,    UC_IDLE};
         default:      w = '{UOP_WAIT,      JC_ALWAYS,    UC_IDLE};
      endcase
      return w;
   endfunction

   // x mod 179 for x below 2^15: reciprocal estimate, one correction
   function automatic logic [LAG_W-1:0] mod179_f(input logic [14:0] x);
      logic [23:0] est;
      logic [7:0]  q;
      logic [15:0] r;
      est = 24'(x) * 24'(LAG_RECIP);
      q   = est[23:16];
      r   = 16'(x) - 16'(q) * 16'(LAG_MOD);
      if (r >= 16'(LAG_MOD)) begin
         r = r - 16'(LAG_MOD);
      end
      return r[LAG_W-1:0];
   endfunction

   // x mod 169 for x below 2^14
   function automatic logic [LAG_W-1:0] mod169_f(input logic [13:0] x);
      logic [23:0] est;
      logic [7:0]  q;
      logic [15:0] r;
      est = 24'(x) * 24'(CONG_RECIP);
      q   = est[23:16];
      r   = 16'(x) - 16'(q) * 16'(CONG_MOD);
      if (r >= 16'(CONG_MOD)) begin
         r = r - 16'(CONG_MOD);
      end
      return r[LAG_W-1:0];
   endfunction

endpackage

>>> hdl/lagged_generator_seed_table_expander.sv
// Seed-table expander for the lagged universal generator. A transaction with
// op 0 loads two seeds (reduced modulo 31329 and 30082) and sets three lag
// values and a congruential value; its response carries word 0, index 0 and
// exhausted 1 and is registered after the seed quotient and seed set steps. A
// transaction with op 1 returns the next table word with its index, or
// exhausted once TABLE_WORDS words have been produced. A word is built bit by
// bit over BITS_PER_WORD sub-steps: a microcoded sequencer drives one shared
// multiply/reduce datapath, and each sub-step walks it in five micro-steps
// (lag product, mod 179, times third lag, mod 179 and lag shift, output bit).
// One transaction is in work at a time; a finished response sits in the
// output register and the next request is taken meanwhile.
module lagged_generator_seed_table_expander
   import lgste_pkg::*;
#(
   parameter int BITS_PER_WORD_P = BITS_PER_WORD
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [SEED_W-1:0]  req_seed_a,
   input  logic [SEED_W-1:0]  req_seed_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [WORD_W-1:0]  rsp_word,
   output logic [INDEX_W-1:0] rsp_word_index,
   output logic               rsp_exhausted
);

   localparam int CNT_W = (BITS_PER_WORD_P > 1) ? $clog2(BITS_PER_WORD_P) : 1;

   // Sequencer
   uc_addr_type pc_ff, pc_in;
   ucode_type   uc;
   logic        req_accept;
   logic        emit;
   logic        stall;
   logic        table_full;

   // Lag state
   logic [LAG_W-1:0]   lag_i_ff, lag_i_in;
   logic [LAG_W-1:0]   lag_j_ff, lag_j_in;
   logic [LAG_W-1:0]   lag_k_ff, lag_k_in;
   logic [LAG_W-1:0]   cong_ff, cong_in;
   logic [INDEX_W-1:0] done_ff, done_in;

   // Working registers
   logic [SEED_W-1:0] seed_a_ff, seed_a_in;
   logic [SEED_W-1:0] seed_b_ff, seed_b_in;
   logic [LAG_W-1:0]  quot_a_ff, quot_a_in;
   logic [LAG_W-1:0]  quot_b_ff, quot_b_in;
   logic [14:0]       prod_ff, prod_in;
   logic [13:0]       cprod_ff, cprod_in;
   logic [LAG_W-1:0]  acc_ff, acc_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_exh_ff, rsp_exh_in;

   // Seed split helpers
   logic [23:0] est_a, est_b;
   logic [15:0] rem_a, rem_b;
   logic [11:0] bit_prod;

   assign uc         = ucode_rom(pc_ff);
   assign req_ready  = (uc.uop == UOP_WAIT);
   assign req_accept = req_valid && req_ready;
   assign emit       = (uc.uop == UOP_EMIT_WORD) || (uc.uop == UOP_EMIT_EXH);
   // hold an emitting step while the previous response is still waiting
   assign stall      = emit && rsp_valid_ff && !rsp_ready;
   assign table_full = (done_ff >= INDEX_W'(TABLE_WORDS));

   // Next step
   always_comb begin
      pc_in = pc_ff;
      if (!stall) begin
         case (uc.jc)
            JC_NEXT:   pc_in = pc_ff + uc_addr_type'(1);
            JC_ALWAYS: pc_in = uc.target;
            JC_DISPATCH: begin
               if (req_accept) begin
                  if (!req_op) begin
                     pc_in = UC_SEED_QUOT;
                  end else if (table_full) begin
                     pc_in = UC_EMIT_EXH;
                  end else begin
                     pc_in = UC_MUL_IJ;
                  end
               end
            end
            JC_BITS_LEFT: begin
               pc_in = (cnt_ff != '0) ? uc.target : pc_ff + uc_addr_type'(1);
            end
            default:   pc_in = UC_IDLE;
         endcase
      end
   end

   // Datapath driven by the current control word
   always_comb begin
      lag_i_in     = lag_i_ff;
      lag_j_in     = lag_j_ff;
      lag_k_in     = lag_k_ff;
      cong_in      = cong_ff;
      done_in      = done_ff;
      seed_a_in    = seed_a_ff;
      seed_b_in    = seed_b_ff;
      quot_a_in    = quot_a_ff;
      quot_b_in    = quot_b_ff;
      prod_in      = prod_ff;
      cprod_in     = cprod_ff;
      acc_in       = acc_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_exh_in   = rsp_exh_ff;
      est_a        = 24'(seed_a_ff) * 24'(SEED_A_RECIP);
      est_b        = 24'(seed_b_ff) * 24'(SEED_B_RECIP);
      rem_a        = 16'(seed_a_ff) - 16'(quot_a_ff) * 16'(SEED_A_DIV);
      rem_b        = 16'(seed_b_ff) - 16'(quot_b_ff) * 16'(SEED_B_DIV);
      bit_prod     = 12'(lag_k_ff[5:0]) * 12'(cong_ff[5:0]);

      // drop the previous response once it is taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (uc.uop)
         UOP_WAIT: begin
            if (req_accept) begin
               // reduce the seeds into range on capture
               seed_a_in = (req_seed_a >= SEED_W'(SEED_A_MOD)) ?
                           req_seed_a - SEED_W'(SEED_A_MOD) : req_seed_a;
               seed_b_in = (req_seed_b >= SEED_W'(SEED_B_MOD)) ?
                           req_seed_b - SEED_W'(SEED_B_MOD) : req_seed_b;
               word_in   = '0;
               cnt_in    = CNT_W'(BITS_PER_WORD_P - 1);
            end
         end
         UOP_SEED_QUOT: begin
            // quotient estimates, at most one short
            quot_a_in = est_a[23:16];
            quot_b_in = est_b[23:16];
         end
         UOP_SEED_SET: begin
            if (rem_a >= 16'(SEED_A_DIV)) begin
               lag_i_in = quot_a_ff + 8'd3;
               lag_j_in = 8'(rem_a - 16'(SEED_A_DIV)) + 8'd2;
            end else begin
               lag_i_in = quot_a_ff + 8'd2;
               lag_j_in = rem_a[LAG_W-1:0] + 8'd2;
            end
            if (rem_b >= 16'(SEED_B_DIV)) begin
               lag_k_in = quot_b_ff + 8'd2;
               cong_in  = 8'(rem_b - 16'(SEED_B_DIV));
            end else begin
               lag_k_in = quot_b_ff + 8'd1;
               cong_in  = rem_b[LAG_W-1:0];
            end
            done_in = '0;
         end
         UOP_MUL_IJ: begin
            prod_in  = 15'(16'(lag_i_ff) * 16'(lag_j_ff));
            cprod_in = 14'(cong_ff) * 14'(CONG_MULT) + 14'd1;
         end
         UOP_RED_1: begin
            acc_in  = mod179_f(prod_ff);
            cong_in = mod169_f(cprod_ff);
         end
         UOP_MUL_K: begin
            prod_in = 15'(16'(acc_ff) * 16'(lag_k_ff));
         end
         UOP_RED_2: begin
            // shift the lags; the new product becomes the third lag
            lag_i_in = lag_j_ff;
            lag_j_in = lag_k_ff;
            lag_k_in = mod179_f(prod_ff);
         end
         UOP_SHIFT_BIT: begin
            word_in = {word_ff[WORD_W-2:0], bit_prod[BIT_POS]};
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         UOP_EMIT_WORD: begin
            if (!stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = word_ff;
               rsp_index_in = done_ff;
               rsp_exh_in   = 1'b0;
               done_in      = done_ff + INDEX_W'(1);
            end
         end
         UOP_EMIT_EXH: begin
            if (!stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               rsp_index_in = '0;
               rsp_exh_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= UC_IDLE;
         rsp_valid_ff <= 1'b0;
         lag_i_ff     <= 8'd2;
         lag_j_ff     <= 8'd2;
         lag_k_ff     <= 8'd1;
         cong_ff      <= '0;
         done_ff      <= '0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         lag_i_ff     <= lag_i_in;
         lag_j_ff     <= lag_j_in;
         lag_k_ff     <= lag_k_in;
         cong_ff      <= cong_in;
         done_ff      <= done_in;
      end
   end

   // Working and response payload
   always_ff @(posedge clock) begin
      seed_a_ff    <= seed_a_in;
      seed_b_ff    <= seed_b_in;
      quot_a_ff    <= quot_a_in;
      quot_b_ff    <= quot_b_in;
      prod_ff      <= prod_in;
      cprod_ff     <= cprod_in;
      acc_ff       <= acc_in;
      word_ff      <= word_in;
      cnt_ff       <= cnt_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_exh_ff   <= rsp_exh_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word       = rsp_word_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_exhausted  = rsp_exh_ff;

   // Lags stay nonzero residues mod 179
   a_lags_range: assert property (@(posedge clock) disable iff (reset)
      lag_i_ff != '0 && lag_j_ff != '0 && lag_k_ff != '0 &&
      lag_i_ff < 8'(LAG_MOD) && lag_j_ff < 8'(LAG_MOD) && lag_k_ff < 8'(LAG_MOD))
      else $error("lag value left the range 1..178");

   a_cong_range: assert property (@(posedge clock) disable iff (reset)
      cong_ff < 8'(CONG_MOD))
      else $error("congruential value not below 169");

   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff <= INDEX_W'(TABLE_WORDS))
      else $error("word count ran past the table");

   a_exh_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exhausted |-> rsp_word == '0 && rsp_word_index == '0)
      else $error("exhausted response carries a word");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      uc.uop == UOP_EMIT_WORD && !stall |=> done_ff == $past(done_ff) + INDEX_W'(1))
      else $error("word count did not advance on a word response");

endmodule
